// File: hdl/button_event_detector_core_assert.svh
// Assertion macros for the button event detector
`ifndef BUTTON_EVENT_DETECTOR_CORE_ASSERT_SVH
`define BUTTON_EVENT_DETECTOR_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Property that must hold in the same cycle
`define BED_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Property that must hold in the next cycle
`define BED_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define BED_ASSERT(lbl, ante, cons, msg)
`define BED_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/bed_pkg.sv
package bed_pkg;

  localparam int KEYS_DEFAULT = 8;

  localparam int CFG_W  = 16;
  localparam int TIME_W = 32;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SHORT  = 2'd1,
    EV_LONG   = 2'd2,
    EV_DOUBLE = 2'd3
  } event_t;

  // Request codes; the fourth code is unused
  localparam logic [1:0] REQ_PIN   = 2'd0;
  localparam logic [1:0] REQ_SWEEP = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_LONG_HOLD   = 3'd0;
  localparam logic [2:0] CFG_REPEAT      = 3'd1;
  localparam logic [2:0] CFG_DEBOUNCE    = 3'd2;
  localparam logic [2:0] CFG_DOUBLE_WIN  = 3'd3;
  localparam logic [2:0] CFG_SHORT_MIN   = 3'd4;

  localparam logic [CFG_W-1:0] LONG_HOLD_RESET  = 16'd1000;
  localparam logic [CFG_W-1:0] REPEAT_RESET     = 16'd200;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd20;
  localparam logic [CFG_W-1:0] DOUBLE_WIN_RESET = 16'd300;
  localparam logic [CFG_W-1:0] SHORT_MIN_RESET  = 16'd50;

  localparam logic [2:0] DOUBLE_CLICKS = 3'd2;

  typedef struct packed {
    logic              level_now;
    logic              level_before;
    logic [TIME_W-1:0] press_stamp;
    logic [TIME_W-1:0] release_stamp;
    logic [TIME_W-1:0] previous_release;
    logic [1:0]        click_count;
    event_t            pending_event;
  } key_state_t;

endpackage

// File: hdl/button_event_detector_core.sv
// Flow: a pin change or read goes from accept through S_RMW and S_DONE to key_event, a sweep
// through S_SWEEP and S_DONE, unused codes and out-of-range keys straight to S_DONE.
// The input stalls until the item has left S_DONE, so a new item waits for the last one;
// the sweep reads and writes the key state memory one key per cycle.
// Reset: control and output cleared, registers to defaults; per-key valid bits make every
// key read as released with zero stamps, so no clearing pass runs.
`include "button_event_detector_core_assert.svh"

module button_event_detector_core import bed_pkg::*; #(
  parameter int KEYS = KEYS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        req_type,
  input  logic [7:0]        key_index,
  input  logic              pin_pressed,
  input  logic [TIME_W-1:0] now_ms,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        key_event,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam logic [KW-1:0] LAST_KEY = KW'(KEYS - 1);

  typedef enum logic [1:0] {S_IDLE, S_RMW, S_SWEEP, S_DONE} state_t;

  state_t            state;
  logic [1:0]        req_q;
  logic [KW-1:0]     key_q;
  logic              pressed_q;
  logic [TIME_W-1:0] now_q;
  logic [KW-1:0]     sidx;
  event_t            res;

  logic [CFG_W-1:0]  long_hold_ms, repeat_interval_ms, debounce_ms;
  logic [CFG_W-1:0]  double_window_ms, short_min_ms;

  key_state_t        mem [KEYS];
  logic [KEYS-1:0]   valid;
  key_state_t        rdata;
  logic              rvalid;
  key_state_t        entry;
  logic [KW-1:0]     raddr;
  logic [KW-1:0]     waddr;
  logic              we;
  key_state_t        wdata;
  key_state_t        swept;
  logic              in_fire;
  logic              key_ok;

  function automatic key_state_t sweep_key(
    key_state_t s, logic [TIME_W-1:0] now, logic [CFG_W-1:0] lh, logic [CFG_W-1:0] rp,
    logic [CFG_W-1:0] db, logic [CFG_W-1:0] dw, logic [CFG_W-1:0] sm);
    key_state_t        n;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] dur;
    logic [TIME_W-1:0] gap;
    logic [2:0]        c;
    n    = s;
    held = now - s.press_stamp;
    dur  = s.release_stamp - s.press_stamp;
    gap  = now - s.previous_release;
    c    = {1'b0, s.click_count} + 3'd1;
    if (s.level_now) begin
      if ((held >= TIME_W'(lh) && s.pending_event == EV_NONE) || held >= TIME_W'(rp)) begin
        n.pending_event = EV_LONG;
        n.press_stamp   = now;
      end
    end else if (s.level_before) begin
      if (dur >= TIME_W'(db)) begin
        if (gap <= TIME_W'(dw)) begin
          if (c >= DOUBLE_CLICKS) begin
            n.pending_event = EV_DOUBLE;
            c = 3'd0;
          end
          n.click_count = c[1:0];
        end else begin
          n.click_count = 2'd1;
        end
        n.previous_release = s.release_stamp;
        if (dur >= TIME_W'(sm) && dur < TIME_W'(lh) && n.pending_event == EV_NONE)
          n.pending_event = EV_SHORT;
      end
      n.level_before = 1'b0;
    end
    return n;
  endfunction

  assign in_stall  = (state != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign key_ok    = (key_index < 8'(KEYS));
  assign entry     = rvalid ? rdata : '0;
  assign swept     = sweep_key(entry, now_q, long_hold_ms, repeat_interval_ms, debounce_ms,
                               double_window_ms, short_min_ms);

  // Read address: the item's key on accept (key 0 for a sweep), the next key during a sweep
  always_comb begin
    if (state == S_SWEEP)
      raddr = (sidx == LAST_KEY) ? '0 : sidx + 1'b1;
    else if (req_type == REQ_SWEEP)
      raddr = '0;
    else
      raddr = key_index[KW-1:0];
  end

  always_comb begin
    we    = 1'b0;
    waddr = key_q;
    wdata = entry;
    if (state == S_SWEEP) begin
      we    = 1'b1;
      waddr = sidx;
      wdata = swept;
    end else if (state == S_RMW) begin
      we = 1'b1;
      if (req_q == REQ_PIN) begin
        wdata.level_before = entry.level_now;
        wdata.level_now    = pressed_q;
        if (pressed_q)
          wdata.press_stamp = now_q;
        else
          wdata.release_stamp = now_q;
      end else begin
        wdata.pending_event = EV_NONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    rdata  <= mem[raddr];
    rvalid <= valid[raddr];
    if (we)
      mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst)
      valid <= '0;
    else if (we)
      valid[waddr] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      long_hold_ms       <= LONG_HOLD_RESET;
      repeat_interval_ms <= REPEAT_RESET;
      debounce_ms        <= DEBOUNCE_RESET;
      double_window_ms   <= DOUBLE_WIN_RESET;
      short_min_ms       <= SHORT_MIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LONG_HOLD:  long_hold_ms       <= cfg_data;
        CFG_REPEAT:     repeat_interval_ms <= cfg_data;
        CFG_DEBOUNCE:   debounce_ms        <= cfg_data;
        CFG_DOUBLE_WIN: double_window_ms   <= cfg_data;
        CFG_SHORT_MIN:  short_min_ms       <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      key_event <= EV_NONE;
      res       <= EV_NONE;
      sidx      <= '0;
      req_q     <= REQ_PIN;
      key_q     <= '0;
      pressed_q <= 1'b0;
      now_q     <= '0;
    end else begin
      // load a finished result, else drop the output word once taken
      if (state == S_DONE && (!out_valid || !out_stall))
        out_valid <= 1'b1;
      else if (out_valid && !out_stall)
        out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            req_q     <= req_type;
            key_q     <= key_index[KW-1:0];
            pressed_q <= pin_pressed;
            now_q     <= now_ms;
            sidx      <= '0;
            res       <= EV_NONE;
            if (req_type == REQ_SWEEP)
              state <= S_SWEEP;
            else if ((req_type == REQ_PIN || req_type == REQ_READ) && key_ok)
              state <= S_RMW;
            else
              state <= S_DONE;
          end
        end
        S_RMW: begin
          res   <= (req_q == REQ_READ) ? entry.pending_event : EV_NONE;
          state <= S_DONE;
        end
        S_SWEEP: begin
          if (sidx == LAST_KEY)
            state <= S_DONE;
          else
            sidx <= sidx + 1'b1;
        end
        S_DONE: begin
          // hold the result until the output register is free
          if (!out_valid || !out_stall) begin
            key_event <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BED_ASSERT_NEXT(a_out_drop, out_valid && !out_stall && state != S_DONE, !out_valid, "output word not dropped after transfer")
  `BED_ASSERT(a_sidx_range, state == S_SWEEP, sidx <= LAST_KEY, "sweep index out of range")
  `BED_ASSERT(a_event_read, state == S_DONE && res != EV_NONE, req_q == REQ_READ, "event raised by a non-read request")

endmodule
